/* sv/rtn_pkg.sv */
// Shared types, constants and the multiply-accumulate sequence of the ray/triangle unit.
`default_nettype none
package rtn_pkg;

  // Datapath widths
  localparam int ACC_W    = 104;  // accumulator, holds every dot product exactly
  localparam int B_W      = 67;   // stored cross products
  localparam int OP_W     = 34;   // multiplier operand
  localparam int PROD_W   = 2 * OP_W;
  localparam int HI_SHIFT = 33;   // weight of the upper half of a split operand
  localparam int T_W      = 31;   // distance result
  localparam int Q_W      = 32;   // quotient bits, top bit flags saturation
  localparam int STEP_W   = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic [STEP_W-1:0] LAST_GEO  = 6'd11;
  localparam logic [STEP_W-1:0] LAST_BARY = 6'd35;
  localparam logic [STEP_W-1:0] LAST_DIV  = 6'd31;
  localparam logic [T_W-1:0]    T_MAX     = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z,
    REG_DIR_X, REG_DIR_Y, REG_DIR_Z,
    REG_DET_EPS, REG_MIN_DIST
  } reg_idx_t;

  typedef enum logic [3:0] {
    A_D0, A_D1, A_D2, A_E1_0, A_E1_1, A_E1_2,
    A_E2_0, A_E2_1, A_E2_2, A_TV0, A_TV1, A_TV2
  } asel_t;

  typedef enum logic [3:0] {
    B_E1_0, B_E1_1, B_E1_2, B_E2_0, B_E2_1, B_E2_2,
    B_TV0, B_TV1, B_TV2, B_P0, B_P1, B_P2, B_Q0, B_Q1, B_Q2
  } bsel_t;

  typedef enum logic [1:0] {PT_FULL, PT_LO, PT_HI} part_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_P0, DST_P1, DST_P2, DST_DET, DST_UN,
    DST_Q0, DST_Q1, DST_Q2, DST_VN, DST_TN
  } dst_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_GEO, ST_DET_WAIT, ST_DET_CHK, ST_BARY, ST_BARY_WAIT,
    ST_BARY_CHK, ST_DIV, ST_UPDATE, ST_FINISH
  } state_t;

  // One multiply-accumulate step
  typedef struct packed {
    asel_t a;
    bsel_t b;
    part_t part;
    logic  sub;
    logic  flip;   // follow the determinant sign
    dst_t  dst;    // store the sum and restart
  } ucode_t;

  typedef struct packed {
    logic   load_in;
    logic   issue;
    ucode_t uc;
    logic   det_fix;
    logic   div_load;
    logic   div_step;
    logic   update;
    logic   emit;
  } dp_cmd_t;

  typedef struct packed {
    logic det_skip;
    logic bary_skip;
    logic last;
  } dp_sts_t;

  typedef struct packed {
    logic signed [31:0] org_x;
    logic signed [31:0] org_y;
    logic signed [31:0] org_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [15:0]        det_eps;
    logic [15:0]        min_dist;
  } cfg_t;

  typedef struct packed {
    logic           hit;
    logic [T_W-1:0] t;
  } result_t;

  function automatic ucode_t uc(input asel_t a, input bsel_t b, input part_t p,
                                input logic s, input logic f, input dst_t d);
    ucode_t r;
    r = '{a, b, p, s, f, d};
    return r;
  endfunction

  // Sequence: P = D x E2, det = E1.P, u = T.P, Q = T x E1, v = D.Q, t = E2.Q
  function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
    ucode_t r;
    unique case (step)
      6'd0:  r = uc(A_D1, B_E2_2, PT_FULL, 1'b0, 1'b0, DST_NONE);
      6'd1:  r = uc(A_D2, B_E2_1, PT_FULL, 1'b1, 1'b0, DST_P0);
      6'd2:  r = uc(A_D2, B_E2_0, PT_FULL, 1'b0, 1'b0, DST_NONE);
      6'd3:  r = uc(A_D0, B_E2_2, PT_FULL, 1'b1, 1'b0, DST_P1);
      6'd4:  r = uc(A_D0, B_E2_1, PT_FULL, 1'b0, 1'b0, DST_NONE);
      6'd5:  r = uc(A_D1, B_E2_0, PT_FULL, 1'b1, 1'b0, DST_P2);
      6'd6:  r = uc(A_E1_0, B_P0, PT_LO, 1'b0, 1'b0, DST_NONE);
      6'd7:  r = uc(A_E1_0, B_P0, PT_HI, 1'b0, 1'b0, DST_NONE);
      6'd8:  r = uc(A_E1_1, B_P1, PT_LO, 1'b0, 1'b0, DST_NONE);
      6'd9:  r = uc(A_E1_1, B_P1, PT_HI, 1'b0, 1'b0, DST_NONE);
      6'd10: r = uc(A_E1_2, B_P2, PT_LO, 1'b0, 1'b0, DST_NONE);
      6'd11: r = uc(A_E1_2, B_P2, PT_HI, 1'b0, 1'b0, DST_DET);
      6'd12: r = uc(A_TV0, B_P0, PT_LO, 1'b0, 1'b1, DST_NONE);
      6'd13: r = uc(A_TV0, B_P0, PT_HI, 1'b0, 1'b1, DST_NONE);
      6'd14: r = uc(A_TV1, B_P1, PT_LO, 1'b0, 1'b1, DST_NONE);
      6'd15: r = uc(A_TV1, B_P1, PT_HI, 1'b0, 1'b1, DST_NONE);
      6'd16: r = uc(A_TV2, B_P2, PT_LO, 1'b0, 1'b1, DST_NONE);
      6'd17: r = uc(A_TV2, B_P2, PT_HI, 1'b0, 1'b1, DST_UN);
      6'd18: r = uc(A_TV1, B_E1_2, PT_FULL, 1'b0, 1'b0, DST_NONE);
      6'd19: r = uc(A_TV2, B_E1_1, PT_FULL, 1'b1, 1'b0, DST_Q0);
      6'd20: r = uc(A_TV2, B_E1_0, PT_FULL, 1'b0, 1'b0, DST_NONE);
      6'd21: r = uc(A_TV0, B_E1_2, PT_FULL, 1'b1, 1'b0, DST_Q1);
      6'd22: r = uc(A_TV0, B_E1_1, PT_FULL, 1'b0, 1'b0, DST_NONE);
      6'd23: r = uc(A_TV1, B_E1_0, PT_FULL, 1'b1, 1'b0, DST_Q2);
      6'd24: r = uc(A_D0, B_Q0, PT_LO, 1'b0, 1'b1, DST_NONE);
      6'd25: r = uc(A_D0, B_Q0, PT_HI, 1'b0, 1'b1, DST_NONE);
      6'd26: r = uc(A_D1, B_Q1, PT_LO, 1'b0, 1'b1, DST_NONE);
      6'd27: r = uc(A_D1, B_Q1, PT_HI, 1'b0, 1'b1, DST_NONE);
      6'd28: r = uc(A_D2, B_Q2, PT_LO, 1'b0, 1'b1, DST_NONE);
      6'd29: r = uc(A_D2, B_Q2, PT_HI, 1'b0, 1'b1, DST_VN);
      6'd30: r = uc(A_E2_0, B_Q0, PT_LO, 1'b0, 1'b1, DST_NONE);
      6'd31: r = uc(A_E2_0, B_Q0, PT_HI, 1'b0, 1'b1, DST_NONE);
      6'd32: r = uc(A_E2_1, B_Q1, PT_LO, 1'b0, 1'b1, DST_NONE);
      6'd33: r = uc(A_E2_1, B_Q1, PT_HI, 1'b0, 1'b1, DST_NONE);
      6'd34: r = uc(A_E2_2, B_Q2, PT_LO, 1'b0, 1'b1, DST_NONE);
      6'd35: r = uc(A_E2_2, B_Q2, PT_HI, 1'b0, 1'b1, DST_TN);
      default: r = uc(A_D0, B_E1_0, PT_FULL, 1'b0, 1'b0, DST_NONE);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/rtn_datapath.sv */
// Datapath: edge setup, shared multiply-accumulate, hit tests, divider and running minimum.
`default_nettype none
module rtn_datapath import rtn_pkg::*; #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cfg_t               cfg,
  input  wire logic signed [31:0] a_x,
  input  wire logic signed [31:0] a_y,
  input  wire logic signed [31:0] a_z,
  input  wire logic signed [31:0] b_x,
  input  wire logic signed [31:0] b_y,
  input  wire logic signed [31:0] b_z,
  input  wire logic signed [31:0] c_x,
  input  wire logic signed [31:0] c_y,
  input  wire logic signed [31:0] c_z,
  input  wire logic               last_triangle,
  input  wire dp_cmd_t            cmd,
  output dp_sts_t                 sts,
  output result_t                 res
);

  localparam int DIV_W = ACC_W + COORD_FRAC_BITS + Q_W;

  logic [32:0] e1 [3];
  logic [32:0] e2 [3];
  logic [32:0] tv [3];
  logic [32:0] dv [3];
  logic        last;

  logic [B_W-1:0]   p0, p1, p2, q0, q1, q2;
  logic [ACC_W-1:0] acc, det, un, vn, tn;
  logic             neg;

  logic [32:0]        a_val;
  logic [B_W-1:0]     b_val;
  logic signed [OP_W-1:0]   a_op, b_op;
  logic signed [PROD_W-1:0] prod;
  logic             pv, p_hi, p_sub;
  dst_t             p_dst;

  logic [ACC_W-1:0] term_ext, term_sh, acc_sum;
  logic [ACC_W-1:0] det_abs, lim;
  logic [ACC_W:0]   uv_sum;

  logic [DIV_W-1:0] rem, dsh;
  logic [DIV_W:0]   diff;
  logic [Q_W-1:0]   quo;
  logic [T_W-1:0]   t_val, best;
  logic             any_hit;

  assign dv[0] = {cfg.dir_x[31], cfg.dir_x};
  assign dv[1] = {cfg.dir_y[31], cfg.dir_y};
  assign dv[2] = {cfg.dir_z[31], cfg.dir_z};

  // Edges and ray offset, taken when a word is accepted
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      e1[0] <= {b_x[31], b_x} - {a_x[31], a_x};
      e1[1] <= {b_y[31], b_y} - {a_y[31], a_y};
      e1[2] <= {b_z[31], b_z} - {a_z[31], a_z};
      e2[0] <= {c_x[31], c_x} - {a_x[31], a_x};
      e2[1] <= {c_y[31], c_y} - {a_y[31], a_y};
      e2[2] <= {c_z[31], c_z} - {a_z[31], a_z};
      tv[0] <= {cfg.org_x[31], cfg.org_x} - {a_x[31], a_x};
      tv[1] <= {cfg.org_y[31], cfg.org_y} - {a_y[31], a_y};
      tv[2] <= {cfg.org_z[31], cfg.org_z} - {a_z[31], a_z};
      last  <= last_triangle;
    end
  end

  // Operand select
  always_comb begin
    case (cmd.uc.a)
      A_D0:    a_val = dv[0];
      A_D1:    a_val = dv[1];
      A_D2:    a_val = dv[2];
      A_E1_0:  a_val = e1[0];
      A_E1_1:  a_val = e1[1];
      A_E1_2:  a_val = e1[2];
      A_E2_0:  a_val = e2[0];
      A_E2_1:  a_val = e2[1];
      A_E2_2:  a_val = e2[2];
      A_TV0:   a_val = tv[0];
      A_TV1:   a_val = tv[1];
      A_TV2:   a_val = tv[2];
      default: a_val = '0;
    endcase
    case (cmd.uc.b)
      B_E1_0:  b_val = {{(B_W-33){e1[0][32]}}, e1[0]};
      B_E1_1:  b_val = {{(B_W-33){e1[1][32]}}, e1[1]};
      B_E1_2:  b_val = {{(B_W-33){e1[2][32]}}, e1[2]};
      B_E2_0:  b_val = {{(B_W-33){e2[0][32]}}, e2[0]};
      B_E2_1:  b_val = {{(B_W-33){e2[1][32]}}, e2[1]};
      B_E2_2:  b_val = {{(B_W-33){e2[2][32]}}, e2[2]};
      B_TV0:   b_val = {{(B_W-33){tv[0][32]}}, tv[0]};
      B_TV1:   b_val = {{(B_W-33){tv[1][32]}}, tv[1]};
      B_TV2:   b_val = {{(B_W-33){tv[2][32]}}, tv[2]};
      B_P0:    b_val = p0;
      B_P1:    b_val = p1;
      B_P2:    b_val = p2;
      B_Q0:    b_val = q0;
      B_Q1:    b_val = q1;
      B_Q2:    b_val = q2;
      default: b_val = '0;
    endcase
    a_op = $signed({a_val[32], a_val});
    case (cmd.uc.part)
      PT_FULL: b_op = $signed(b_val[OP_W-1:0]);
      PT_LO:   b_op = $signed({1'b0, b_val[HI_SHIFT-1:0]});
      PT_HI:   b_op = $signed(b_val[B_W-1:HI_SHIFT]);
      default: b_op = '0;
    endcase
  end

  // Multiplier stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= cmd.issue;
    end
    prod  <= a_op * b_op;
    p_hi  <= (cmd.uc.part == PT_HI);
    p_sub <= cmd.uc.sub ^ (cmd.uc.flip & neg);
    p_dst <= cmd.uc.dst;
  end

  // Accumulate stage
  assign term_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign term_sh  = p_hi ? (term_ext << HI_SHIFT) : term_ext;
  assign acc_sum  = acc + (p_sub ? ~term_sh : term_sh) + {{(ACC_W-1){1'b0}}, p_sub};

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      acc <= '0;
    end else if (pv) begin
      acc <= (p_dst == DST_NONE) ? acc_sum : '0;
      case (p_dst)
        DST_P0:  p0 <= acc_sum[B_W-1:0];
        DST_P1:  p1 <= acc_sum[B_W-1:0];
        DST_P2:  p2 <= acc_sum[B_W-1:0];
        DST_Q0:  q0 <= acc_sum[B_W-1:0];
        DST_Q1:  q1 <= acc_sum[B_W-1:0];
        DST_Q2:  q2 <= acc_sum[B_W-1:0];
        DST_DET: det <= acc_sum;
        DST_UN:  un <= acc_sum;
        DST_VN:  vn <= acc_sum;
        DST_TN:  tn <= acc_sum;
        default: ;
      endcase
    end
    // determinant made positive, sign kept for u, v, t
    if (cmd.det_fix) begin
      det <= det_abs;
      neg <= det[ACC_W-1];
    end
  end

  // Parallel and inside tests
  assign det_abs = det[ACC_W-1] ? (~det + {{(ACC_W-1){1'b0}}, 1'b1}) : det;
  assign lim     = {{(ACC_W-16){1'b0}}, cfg.det_eps} << (2 * COORD_FRAC_BITS);
  assign uv_sum  = {1'b0, un} + {1'b0, vn};

  assign sts.det_skip  = (det_abs <= lim);
  assign sts.bary_skip = un[ACC_W-1] || (un > det) || vn[ACC_W-1] ||
                         (uv_sum > {1'b0, det}) || tn[ACC_W-1] || (tn == '0);
  assign sts.last      = last;

  // Restoring divider, one quotient bit a cycle
  assign diff = {1'b0, rem} - {1'b0, dsh};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem <= {{(DIV_W-ACC_W){1'b0}}, tn} << COORD_FRAC_BITS;
      dsh <= {{(DIV_W-ACC_W){1'b0}}, det} << (Q_W - 1);
      quo <= '0;
    end else if (cmd.div_step) begin
      if (!diff[DIV_W]) begin
        rem <= diff[DIV_W-1:0];
      end
      quo <= {quo[Q_W-2:0], !diff[DIV_W]};
      dsh <= dsh >> 1;
    end
  end

  // Running minimum
  assign t_val = quo[Q_W-1] ? T_MAX : quo[T_W-1:0];

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      best    <= T_MAX;
      any_hit <= 1'b0;
    end else if (cmd.update) begin
      if (t_val > {{(T_W-16){1'b0}}, cfg.min_dist}) begin
        any_hit <= 1'b1;
        if (t_val < best) begin
          best <= t_val;
        end
      end
    end
  end

  assign res.hit = any_hit;
  assign res.t   = any_hit ? best : '0;

endmodule
`default_nettype wire

/* sv/rtn_ctrl.sv */
// Sequencer: walks the multiply-accumulate steps, the tests, the divider and the result hand-off.
`default_nettype none
module rtn_ctrl import rtn_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    out_free,
  input  wire dp_sts_t sts,
  output logic         in_ready,
  output dp_cmd_t      cmd
);

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.uc     = ucode(step);
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          step_next   = '0;
          state_next  = ST_GEO;
        end
      end
      ST_GEO: begin
        cmd.issue = 1'b1;
        step_next = step + 1'b1;
        if (step == LAST_GEO) state_next = ST_DET_WAIT;
      end
      ST_DET_WAIT: state_next = ST_DET_CHK;
      ST_DET_CHK: begin
        cmd.det_fix = 1'b1;
        state_next  = sts.det_skip ? ST_FINISH : ST_BARY;
      end
      ST_BARY: begin
        cmd.issue = 1'b1;
        step_next = step + 1'b1;
        if (step == LAST_BARY) state_next = ST_BARY_WAIT;
      end
      ST_BARY_WAIT: state_next = ST_BARY_CHK;
      ST_BARY_CHK: begin
        cmd.div_load = 1'b1;
        step_next    = '0;
        state_next   = sts.bary_skip ? ST_FINISH : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == LAST_DIV) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        // a mesh's last triangle waits for the output word to be free
        if (!sts.last) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef SYNTH
  a_emit_last: assert property (@(posedge clk) disable iff (rst) cmd.emit |-> sts.last)
    else $error("result emitted for a triangle that is not last");
  a_geo_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GEO) |-> (step <= LAST_GEO))
    else $error("geometry step past its end");
  a_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid) |=> (state == ST_GEO && step == '0))
    else $error("accepted word did not start the sequence");
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BARY_CHK && !sts.bary_skip) |=> (state == ST_DIV && step == '0))
    else $error("divider did not start from step zero");
`endif

endmodule
`default_nettype wire

/* sv/ray_triangle_nearest_hit.sv */
// A triangle that reaches the divider runs all 36 steps through the single 34x34
// multiplier and then 32 divider steps; a parallel one ends after the determinant test and
// one failing the inside test before the divider. One triangle is in work at a time.
// A result word appears in the cycle after the last triangle finishes and is held in an
// output register, so the next triangle is accepted while it waits. Reset (synchronous)
// loads the register defaults and clears the running minimum; no clearing pass is needed.
`default_nettype none
module ray_triangle_nearest_hit import rtn_pkg::*; #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic signed [31:0]   a_x,
  input  wire logic signed [31:0]   a_y,
  input  wire logic signed [31:0]   a_z,
  input  wire logic signed [31:0]   b_x,
  input  wire logic signed [31:0]   b_y,
  input  wire logic signed [31:0]   b_z,
  input  wire logic signed [31:0]   c_x,
  input  wire logic signed [31:0]   c_y,
  input  wire logic signed [31:0]   c_z,
  input  wire logic                 last_triangle,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      hit_found,
  output logic [T_W-1:0]            nearest_t
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;
  result_t res;
  logic    in_ready;
  logic    out_free;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.org_x    <= '0;
      cfg.org_y    <= '0;
      cfg.org_z    <= '0;
      cfg.dir_x    <= '0;
      cfg.dir_y    <= '0;
      cfg.dir_z    <= 32'sd65536;
      cfg.det_eps  <= 16'd1;
      cfg.min_dist <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ORIGIN_X: cfg.org_x    <= cfg_data;
        REG_ORIGIN_Y: cfg.org_y    <= cfg_data;
        REG_ORIGIN_Z: cfg.org_z    <= cfg_data;
        REG_DIR_X:    cfg.dir_x    <= cfg_data;
        REG_DIR_Y:    cfg.dir_y    <= cfg_data;
        REG_DIR_Z:    cfg.dir_z    <= cfg_data;
        REG_DET_EPS:  cfg.det_eps  <= cfg_data[15:0];
        REG_MIN_DIST: cfg.min_dist <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign in_stall = !in_ready;
  assign out_free = !out_valid || !out_stall;

  rtn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  rtn_datapath #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .a_x           (a_x),
    .a_y           (a_y),
    .a_z           (a_z),
    .b_x           (b_x),
    .b_y           (b_y),
    .b_z           (b_z),
    .c_x           (c_x),
    .c_y           (c_y),
    .c_z           (c_z),
    .last_triangle (last_triangle),
    .cmd           (cmd),
    .sts           (sts),
    .res           (res)
  );

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      hit_found <= res.hit;
      nearest_t <= res.t;
    end
  end

endmodule
`default_nettype wire
